>>> rtl/variable_length_record_deframer_unit_defines.svh
// ----------------------------------------------------------------------------
// variable_length_record_deframer_unit_defines.svh
// Assertion macros used by the deframer unit RTL.
// ----------------------------------------------------------------------------
`ifndef VARIABLE_LENGTH_RECORD_DEFRAMER_UNIT_DEFINES_SVH
`define VARIABLE_LENGTH_RECORD_DEFRAMER_UNIT_DEFINES_SVH

// Checked at every clock edge outside reset.
`define VLRD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checked at every clock edge, reset included.
`define VLRD_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

>>> rtl/vlrd_pkg.sv
// ----------------------------------------------------------------------------
// vlrd_pkg
// Types, codes and constants of the variable length record deframer.
// ----------------------------------------------------------------------------
package vlrd_pkg;

  localparam int LEN_W      = 15;
  localparam int CFG_IDX_W  = 2;
  localparam int MAX_RES    = 3;
  localparam int RES_CNT_W  = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_VFC_MODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_LEN  = 2'd1;

  localparam logic [LEN_W-1:0] MAX_LEN_RESET = 15'd1023;
  localparam logic [7:0]       LINE_FEED     = 8'd10;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_TOO_LONG  = 2'd1;
  localparam logic [1:0] ST_TRUNCATED = 2'd2;

  typedef enum logic [2:0] {
    PH_LEN_LO = 3'd0,
    PH_LEN_HI = 3'd1,
    PH_HDR0   = 3'd2,
    PH_HDR1   = 3'd3,
    PH_DATA   = 3'd4,
    PH_PAD    = 3'd5,
    PH_HALT   = 3'd6
  } phase_t;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_input;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       last;
    logic [1:0] status;
  } out_item_t;

  typedef struct packed {
    phase_t           phase;
    logic [7:0]       len_lo;
    logic [LEN_W-1:0] remaining;
    logic             odd_len;
    logic             raw_next;
    logic             failed;
  } state_t;

  typedef struct packed {
    logic             vfc_mode;
    logic [LEN_W-1:0] max_len;
  } cfg_t;

endpackage

>>> rtl/vlrd_step.sv
// ----------------------------------------------------------------------------
// vlrd_step
// Per-byte parser: next deframer state and up to three results.
// ----------------------------------------------------------------------------
module vlrd_step
  import vlrd_pkg::*;
(
  input  cfg_t                    cfg,
  input  state_t                  st_i,
  input  in_item_t                item,
  output state_t                  st_o,
  output out_item_t [MAX_RES-1:0] res,
  output logic [RES_CNT_W-1:0]    res_cnt
);

  logic [15:0]        word;
  logic signed [16:0] len;
  logic               hdr;
  logic [LEN_W-1:0]   rem_dec;
  state_t             st;
  logic [RES_CNT_W-1:0] n;
  logic [1:0]         stat;

  always_comb begin
    word    = {item.in_byte, st_i.len_lo};
    hdr     = cfg.vfc_mode && !st_i.raw_next;
    len     = $signed({word[15], word}) - (hdr ? 17'sd2 : 17'sd0);
    rem_dec = (st_i.remaining != '0) ? st_i.remaining - 15'd1 : st_i.remaining;
    st      = st_i;
    n       = '0;
    res     = '0;
    stat    = ST_OK;

    case (st_i.phase)
      PH_LEN_LO: begin
        st.len_lo = item.in_byte;
        st.phase  = PH_LEN_HI;
      end
      PH_LEN_HI: begin
        if (len > $signed({2'b00, cfg.max_len})) begin
          st.failed = 1'b1;
          st.phase  = PH_HALT;
        end else begin
          if (len <= 17'sd0) begin
            st.raw_next  = 1'b1;
            st.remaining = '0;
          end else begin
            st.raw_next  = 1'b0;
            st.remaining = len[LEN_W-1:0];
            st.odd_len   = len[0];
          end
          if (hdr) begin
            st.phase = PH_HDR0;
          end else begin
            st.phase = (st.remaining != '0) ? PH_DATA : PH_LEN_LO;
          end
        end
      end
      PH_HDR0: begin
        st.phase = PH_HDR1;
      end
      PH_HDR1: begin
        st.phase = (st_i.remaining != '0) ? PH_DATA : PH_LEN_LO;
      end
      PH_DATA: begin
        res[0].out_byte   = item.in_byte;
        res[0].byte_valid = 1'b1;
        n                 = 2'd1;
        st.remaining      = rem_dec;
        if (rem_dec == '0) begin
          res[1].out_byte   = LINE_FEED;
          res[1].byte_valid = 1'b1;
          n                 = 2'd2;
          st.phase          = st_i.odd_len ? PH_PAD : PH_LEN_LO;
        end
      end
      PH_PAD: begin
        st.phase = PH_LEN_LO;
      end
      default: begin
      end
    endcase

    if (item.end_of_input) begin
      if (st.failed) begin
        stat = ST_TOO_LONG;
      end else if (st.phase != PH_LEN_LO) begin
        stat = ST_TRUNCATED;
      end
      res[n].last   = 1'b1;
      res[n].status = stat;
      n             = n + 2'd1;
      st            = '{phase: PH_LEN_LO, len_lo: '0, remaining: '0,
                        odd_len: 1'b0, raw_next: 1'b0, failed: 1'b0};
    end

    st_o    = st;
    res_cnt = n;
  end

endmodule

>>> rtl/variable_length_record_deframer_unit.sv
// ----------------------------------------------------------------------------
// variable_length_record_deframer_unit
// Converts length-prefixed records into line-feed terminated text.
// ----------------------------------------------------------------------------
// Input: one raw byte per transaction on in_valid/in_ready, with
// end_of_input set on the last byte of a file. Output: text bytes, the
// line feed ending each record, and one status transaction (last = 1)
// after end of input, on out_valid/out_ready.
// Configuration: cfg_wr_en/cfg_index/cfg_wdata, written while idle.
// Timing: an accepted byte waits in the input register until it is parsed;
// its first result is presented in the cycle after it is parsed.
// Throughput: one input byte per cycle while each byte yields at most one
// result with out_ready high. The output port moves one result per cycle,
// so a byte that ends a record (data + line feed) or ends input holds the
// next byte until its extra results leave the three-entry result register.
// Reset: parser state returns to expecting a length word, vfc_mode = 0,
// max_record_length = 1023, no results pending.
// Stall: while out_ready is low the pending results hold; the input
// register still takes one more byte, then in_ready drops.
// ----------------------------------------------------------------------------
`include "variable_length_record_deframer_unit_defines.svh"

module variable_length_record_deframer_unit
  import vlrd_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  in_item_t             in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_item_t            out_data,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [LEN_W-1:0]     cfg_wdata
);

  cfg_t                    cfg_r;
  state_t                  st_r, st_nxt;
  logic                    in_vld_r;
  in_item_t                in_q_r;
  out_item_t [MAX_RES-1:0] res_q_r, res_nxt;
  logic [RES_CNT_W-1:0]    res_cnt_r, step_cnt;
  logic                    load, take, in_take;

  vlrd_step u_step (
    .cfg     (cfg_r),
    .st_i    (st_r),
    .item    (in_q_r),
    .st_o    (st_nxt),
    .res     (res_nxt),
    .res_cnt (step_cnt)
  );

  assign out_valid = (res_cnt_r != '0);
  assign out_data  = res_q_r[0];
  assign take      = out_valid && out_ready;
  assign load      = in_vld_r && ((res_cnt_r == '0) || ((res_cnt_r == 2'd1) && out_ready));
  assign in_ready  = !in_vld_r || load;
  assign in_take   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.vfc_mode <= 1'b0;
      cfg_r.max_len  <= MAX_LEN_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_VFC_MODE: cfg_r.vfc_mode <= cfg_wdata[0];
        CFG_MAX_LEN:  cfg_r.max_len  <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r      <= '{phase: PH_LEN_LO, len_lo: '0, remaining: '0,
                     odd_len: 1'b0, raw_next: 1'b0, failed: 1'b0};
      in_vld_r  <= 1'b0;
      res_cnt_r <= '0;
    end else begin
      if (in_take) begin
        in_vld_r <= 1'b1;
      end else if (load) begin
        in_vld_r <= 1'b0;
      end
      if (load) begin
        st_r      <= st_nxt;
        res_cnt_r <= step_cnt;
      end else if (take) begin
        res_cnt_r <= res_cnt_r - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_q_r <= in_data;
    end
    if (load) begin
      res_q_r <= res_nxt;
    end else if (take) begin
      res_q_r <= {res_q_r[MAX_RES-1], res_q_r[MAX_RES-1:1]};
    end
  end

  `VLRD_ASSERT(a_cnt_range, res_cnt_r <= 2'd3, "result count out of range")
  `VLRD_ASSERT(a_status_last, (res_cnt_r > 2'd1) |-> !res_q_r[0].last,
               "status result not last of its group")
  `VLRD_ASSERT(a_halt_no_text, (load && st_r.failed) |=> !(out_valid && out_data.byte_valid),
               "text emitted after length failure")
  `VLRD_ASSERT_ALWAYS(a_reset_idle, !rst_n |=> !out_valid && !in_vld_r,
                      "pending work after reset")

endmodule

>>> test/deframer_checker.sv
// ----------------------------------------------------------------------------
// deframer_checker
// Predicts and checks the text and status stream of the record deframer.
// ----------------------------------------------------------------------------
// Watches the input, output and configuration ports. Each accepted input
// transaction is run through a local model of the length-word parser. The
// model queues the text bytes, line feeds and final status it should cause.
// Each accepted output transaction is compared field by field with the
// oldest queued entry.
// ----------------------------------------------------------------------------
module deframer_checker
  import vlrd_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_ready,
  input  in_item_t             in_data,
  input  logic                 out_valid,
  input  logic                 out_ready,
  input  out_item_t            out_data,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [LEN_W-1:0]     cfg_wdata,
  output int                   mismatch_count,
  output int                   pending_count
);
  timeunit 1ns;
  timeprecision 1ps;

  logic             vfc_mode;
  logic [LEN_W-1:0] max_len;

  phase_t           phase;
  logic [7:0]       len_lo;
  logic [LEN_W-1:0] remaining;
  logic             odd_len;
  logic             raw_next;
  logic             failed;

  out_item_t expected_text_q[$];

  function automatic void clear_stream();
    phase     = PH_LEN_LO;
    len_lo    = '0;
    remaining = '0;
    odd_len   = 1'b0;
    raw_next  = 1'b0;
    failed    = 1'b0;
  endfunction

  function automatic void queue_text(logic [7:0] b, logic v, logic l, logic [1:0] s);
    out_item_t r;
    r.out_byte   = b;
    r.byte_valid = v;
    r.last       = l;
    r.status     = s;
    expected_text_q.push_back(r);
  endfunction

  function automatic void deframe_byte(in_item_t item);
    logic [15:0] word;
    int          len;
    logic        hdr;
    case (phase)
      PH_LEN_LO: begin
        len_lo = item.in_byte;
        phase  = PH_LEN_HI;
      end
      PH_LEN_HI: begin
        word = {item.in_byte, len_lo};
        len  = int'($signed(word));
        hdr  = vfc_mode && !raw_next;
        if (hdr) len -= 2;
        if (len > int'(max_len)) begin
          failed = 1'b1;
          phase  = PH_HALT;
        end else begin
          if (len <= 0) begin
            raw_next  = 1'b1;
            remaining = '0;
          end else begin
            raw_next  = 1'b0;
            remaining = len[LEN_W-1:0];
            odd_len   = len[0];
          end
          if (hdr) phase = PH_HDR0;
          else phase = (remaining != 0) ? PH_DATA : PH_LEN_LO;
        end
      end
      PH_HDR0: phase = PH_HDR1;
      PH_HDR1: phase = (remaining != 0) ? PH_DATA : PH_LEN_LO;
      PH_DATA: begin
        queue_text(item.in_byte, 1'b1, 1'b0, ST_OK);
        if (remaining != 0) remaining--;
        if (remaining == 0) begin
          queue_text(LINE_FEED, 1'b1, 1'b0, ST_OK);
          phase = odd_len ? PH_PAD : PH_LEN_LO;
        end
      end
      PH_PAD: phase = PH_LEN_LO;
      default: ;
    endcase
    if (item.end_of_input) begin
      queue_text(8'd0, 1'b0, 1'b1,
                 failed ? ST_TOO_LONG : ((phase != PH_LEN_LO) ? ST_TRUNCATED : ST_OK));
      clear_stream();
    end
  endfunction

  task automatic report_mismatch(string what, logic [7:0] got, logic [7:0] want);
    if (mismatch_count < 100)
      $display("[%0t] mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
    mismatch_count++;
  endtask

  task automatic check_text();
    out_item_t want;
    if (expected_text_q.size() == 0) begin
      report_mismatch("unexpected transaction, out_byte", out_data.out_byte, 8'd0);
    end else begin
      want = expected_text_q.pop_front();
      if (out_data.out_byte !== want.out_byte)
        report_mismatch("out_byte", out_data.out_byte, want.out_byte);
      if (out_data.byte_valid !== want.byte_valid)
        report_mismatch("byte_valid", 8'(out_data.byte_valid), 8'(want.byte_valid));
      if (out_data.last !== want.last)
        report_mismatch("last", 8'(out_data.last), 8'(want.last));
      if (out_data.status !== want.status)
        report_mismatch("status", 8'(out_data.status), 8'(want.status));
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      vfc_mode = 1'b0;
      max_len  = MAX_LEN_RESET;
      clear_stream();
      expected_text_q.delete();
      mismatch_count = 0;
    end else begin
      if (cfg_wr_en === 1'b1) begin
        if (cfg_index == CFG_VFC_MODE) vfc_mode = cfg_wdata[0];
        else if (cfg_index == CFG_MAX_LEN) max_len = cfg_wdata;
      end
      if (out_valid === 1'b1 && out_ready) check_text();
      if (in_valid && in_ready === 1'b1) deframe_byte(in_data);
    end
    pending_count = expected_text_q.size();
  end

endmodule

>>> test/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the variable length record deframer.
// ----------------------------------------------------------------------------
// Drives record streams into the block: a directed set of edge cases, then
// random streams of mostly well-formed records mixed with padding words,
// over-limit lengths, noise bytes and cut-off endings, over several
// configuration settings. Both sides idle at random; one stretch runs
// without gaps and one holds the receiver off long enough to stall the
// input. The checker instance predicts and compares every result.
// ----------------------------------------------------------------------------
module testbench
  import vlrd_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  in_item_t             in_data;
  logic                 out_valid;
  logic                 out_ready;
  out_item_t            out_data;
  logic                 cfg_wr_en;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [LEN_W-1:0]     cfg_wdata;
  int                   mismatch_count;
  int                   pending_count;

  logic [7:0] frame_q[$];
  logic       cur_vfc;
  int         cur_max;
  logic       gen_raw_next;
  bit         no_idle;
  int         rx_hold;

  always #1 clk = ~clk;

  variable_length_record_deframer_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  deframer_checker u_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_data        (in_data),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_data       (out_data),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .mismatch_count (mismatch_count),
    .pending_count  (pending_count)
  );

  // receiver: random backpressure, plus a counted hold-off on request
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_hold > 0) begin
        out_ready <= 1'b0;
        rx_hold--;
      end else begin
        out_ready <= no_idle || ($urandom_range(99) >= 38);
      end
    end
  end

  task automatic send_byte(logic [7:0] b, logic eoi);
    while (!no_idle && $urandom_range(99) < 38) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{in_byte: b, end_of_input: eoi};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_stream(int count);
    for (int i = 0; i < count; i++) send_byte(frame_q[i], i == count - 1);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (pending_count != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic set_config(logic vfc, int max);
    cfg_wr_en <= 1'b1;
    cfg_index <= CFG_VFC_MODE;
    cfg_wdata <= LEN_W'(vfc);
    @(negedge clk);
    cfg_index <= CFG_MAX_LEN;
    cfg_wdata <= LEN_W'(max);
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    cur_vfc = vfc;
    cur_max = max;
  endtask

  task automatic add_record(int eff);
    int   word;
    logic hdr;
    hdr  = cur_vfc && !gen_raw_next;
    word = eff + (hdr ? 2 : 0);
    frame_q.push_back(word[7:0]);
    frame_q.push_back(word[15:8]);
    if (eff <= cur_max) begin
      if (hdr) repeat (2) frame_q.push_back(8'($urandom));
      if (eff <= 0) begin
        gen_raw_next = 1'b1;
      end else begin
        gen_raw_next = 1'b0;
        repeat (eff) frame_q.push_back(8'($urandom));
        if (eff % 2 == 1) frame_q.push_back(8'($urandom));
      end
    end
  endtask

  task automatic send_random_stream();
    int   kind;
    int   eff;
    int   count;
    logic hdr;
    frame_q.delete();
    gen_raw_next = 1'b0;
    repeat ($urandom_range(1, 2)) begin
      kind = $urandom_range(99);
      hdr  = cur_vfc && !gen_raw_next;
      if (kind >= 90) begin
        repeat ($urandom_range(1, 3)) frame_q.push_back(8'($urandom));
      end else begin
        if (kind < 70) eff = $urandom_range(1, 9);
        else if (kind < 80) eff = 0 - int'($urandom_range(0, 4));
        else if (kind < 83) eff = hdr ? -32770 : -32768;
        else if (cur_max < 32760) eff = cur_max + 1 + int'($urandom_range(0, 3));
        else eff = $urandom_range(1, 9);
        add_record(eff);
      end
    end
    count = frame_q.size();
    if (count > 1 && $urandom_range(99) < 25)
      count -= $urandom_range(1, (count > 3) ? 3 : count - 1);
    send_stream(count);
  endtask

  initial begin
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_data      = '0;
    cfg_wr_en    = 1'b0;
    cfg_index    = CFG_VFC_MODE;
    cfg_wdata    = '0;
    no_idle      = 1'b0;
    rx_hold      = 0;
    cur_vfc      = 1'b0;
    cur_max      = int'(MAX_LEN_RESET);
    gen_raw_next = 1'b0;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // odd record with NUL/FF/LF bytes and pad, zero padding word, end on last data byte
    frame_q = '{8'h03, 8'h00, 8'h00, 8'hFF, 8'h0A, 8'h5A,
                8'h00, 8'h00, 8'h02, 8'h00, 8'h80, 8'h7F};
    send_stream(frame_q.size());
    // negative padding, then end before the pad byte
    frame_q = '{8'hFF, 8'hFF, 8'h01, 8'h00, 8'h55};
    send_stream(frame_q.size());
    // one above the limit, then end while halted
    frame_q = '{8'h00, 8'h04, 8'h33};
    send_stream(frame_q.size());
    settle();

    // most negative word with header, then largest raw length, cut short
    set_config(1'b1, 32767);
    frame_q = '{8'h00, 8'h80, 8'($urandom), 8'($urandom), 8'hFF, 8'h7F, 8'hA5};
    send_stream(frame_q.size());
    settle();

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: set_config(1'b1, 1023);
        1: set_config(1'b0, 1);
        2: set_config(1'b1, 0);
        3: set_config(1'b0, 32767);
        4: set_config(1'b1, 6);
        default: set_config(1'($urandom_range(0, 1)), $urandom_range(0, 20));
      endcase
      no_idle = (ph == 3);
      repeat (1) send_random_stream();
      if (ph == 3) begin
        frame_q.delete();
        gen_raw_next = 1'b0;
        add_record(40);
        rx_hold = 300;
        send_stream(frame_q.size());
      end
      settle();
    end
    no_idle = 1'b0;

    if (mismatch_count == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

  initial begin
    #200us;
    $display("== FAIL ==");
    $finish;
  end

endmodule

>>> sim.f
+incdir+rtl
rtl/vlrd_pkg.sv
rtl/vlrd_step.sv
rtl/variable_length_record_deframer_unit.sv
test/deframer_checker.sv
test/testbench.sv
